FILE: rtl/core/sioreg_pkg.sv
// Shared types, constants and helper functions of the Super I/O configuration register file.
package sioreg_pkg;

   localparam int REG_COUNT = 256;
   localparam int REG_AW    = $clog2(REG_COUNT);
   localparam int DEV_COUNT = 8;
   localparam int CSR_AW    = 4;

   localparam logic [1:0] CSR_CHIP_VARIANT = 2'd0;
   localparam logic [1:0] CSR_BASE_SELECT  = 2'd1;
   localparam logic [1:0] CSR_INITIAL_KEY  = 2'd2;

   localparam logic [9:0] PORT_KEY_250  = 10'h250;
   localparam logic [9:0] PORT_INDEX_250 = 10'h251;
   localparam logic [9:0] PORT_DATA_250 = 10'h252;
   localparam logic [9:0] PORT_INDEX_3F0 = 10'h3f0;
   localparam logic [9:0] PORT_DATA_3F0 = 10'h3f1;

   localparam logic [7:0] IDX_CHIP_ID = 8'h09;
   localparam logic [7:0] IDX_KEY_SEL = 8'h0c;
   localparam logic [7:0] IDX_MAPPING = 8'h16;
   localparam logic [7:0] IDX_FDC     = 8'h20;
   localparam logic [7:0] IDX_LPT     = 8'h23;
   localparam logic [7:0] IDX_LAST_DEV = 8'h29;

   localparam logic [7:0] LOCK_BYTE    = 8'haa;
   localparam logic [7:0] MAP_IGNORED  = 8'h02;
   localparam logic [7:0] BYTE_ALL_ONES = 8'hff;
   localparam logic [7:0] KEY_SEL_LOW  = 8'h08;
   localparam logic [7:0] KEY_SEL_HIGH = 8'h28;
   localparam logic [7:0] MAP_250_DEF  = 8'h04;
   localparam logic [7:0] MAP_3F0_DEF  = 8'h05;
   localparam logic [7:0] KEY_250_LOW  = 8'h88;
   localparam logic [7:0] KEY_3F0_LOW  = 8'h86;

   localparam logic [2:0] DEV_FDC   = 3'd0;
   localparam logic [2:0] DEV_LPT   = 3'd1;
   localparam logic [2:0] DEV_UART1 = 3'd2;
   localparam logic [2:0] DEV_UART2 = 3'd3;
   localparam logic [2:0] DEV_IRQ   = 3'd6;

   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } state_type;

   typedef struct packed {
      logic       chip_variant;
      logic       base_select;
      logic [7:0] initial_key;
   } cfg_type;

   typedef struct packed {
      logic       fdc_on;
      logic       fdc_shared_port_on;
      logic       lpt_on;
      logic [9:0] lpt_base;
      logic       uart1_on;
      logic [9:0] uart1_base;
      logic [3:0] uart1_irq;
      logic       uart2_on;
      logic [9:0] uart2_base;
      logic [3:0] uart2_irq;
   } dev_status_type;

   typedef struct packed {
      logic       use_mem;
      logic [7:0] value;
   } rd_sel_type;

   function automatic logic [7:0] pick_key(input logic alt_map, input logic [7:0] key_sel);
      logic hi;
      hi = key_sel[5];
      if (alt_map) begin
         pick_key = hi ? 8'h87 : 8'h86;
      end else begin
         pick_key = hi ? 8'h89 : 8'h88;
      end
   endfunction

   function automatic logic [7:0] chip_id(input logic variant);
      chip_id = variant ? 8'h0c : 8'h0a;
   endfunction

   function automatic logic [7:0] mem_default(input logic [7:0] idx);
      case (idx)
         8'h03: mem_default = 8'h30;
         8'h09: mem_default = 8'h0c;
         8'h0b: mem_default = 8'h0c;
         8'h0d: mem_default = 8'ha3;
         default: mem_default = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] dev_default(input logic [2:0] slot);
      case (slot)
         3'd0: dev_default = 8'hfc;
         3'd1: dev_default = 8'hde;
         3'd2: dev_default = 8'hfe;
         3'd3: dev_default = 8'hbe;
         3'd4: dev_default = 8'h23;
         3'd5: dev_default = 8'h05;
         3'd6: dev_default = 8'h43;
         default: dev_default = 8'h60;
      endcase
   endfunction

endpackage

FILE: rtl/core/sioreg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sioreg_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sioreg_core.sv
// Unlock sequencing, index and data port decode, device registers and the register memory.
module sioreg_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    init,
   input  sioreg_pkg::cfg_type     cfg,
   input  logic                    accept,
   input  logic                    opcode,
   input  logic [9:0]              io_address,
   input  logic [7:0]              write_data,
   output logic [7:0]              rd_data,
   output sioreg_pkg::dev_status_type status
);
   import sioreg_pkg::*;

   logic             unlocked_ff, unlocked_in;
   logic             claim_ff, claim_in;
   logic [7:0]       index_ff, index_in;
   logic [7:0]       key_last_ff, key_last_in;
   logic [7:0]       key_prev_ff, key_prev_in;
   logic [7:0]       active_key_ff, active_key_in;
   logic [7:0]       key_sel_ff, key_sel_in;
   logic [7:0]       mapping_ff, mapping_in;
   logic [7:0]       dev_ff [DEV_COUNT];
   logic [7:0]       dev_in [DEV_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   rd_sel_type       rd_sel_ff, rd_sel_in;

   logic             alt_map;
   logic             data_wr;
   logic             data_rd;
   logic             in_range;
   logic             is_dev;
   logic [2:0]       dev_slot;
   logic [REG_AW-1:0] mem_addr;
   logic             mem_we;
   logic             key_hit;
   logic [7:0]       mem_rdata;

   assign alt_map  = mapping_ff[0];
   assign in_range = {1'b0, index_ff} < 9'(REG_COUNT);
   assign mem_addr = index_ff[REG_AW-1:0];
   assign is_dev   = (index_ff == IDX_FDC) ||
                     ((index_ff >= IDX_LPT) && (index_ff <= IDX_LAST_DEV));
   assign dev_slot = (index_ff == IDX_FDC) ? DEV_FDC : 3'(index_ff - 8'h22);
   assign key_hit  = (write_data == active_key_ff) && (key_last_ff == active_key_ff);

   always_comb begin
      data_wr = 1'b0;
      data_rd = 1'b0;
      if (!alt_map) begin
         data_wr = opcode && (io_address == PORT_DATA_250) && unlocked_ff;
         data_rd = !opcode && (io_address == PORT_DATA_250) && unlocked_ff;
      end else begin
         data_wr = opcode && (io_address == PORT_DATA_3F0) && unlocked_ff;
         data_rd = !opcode && (io_address == PORT_DATA_3F0) && unlocked_ff;
      end
   end

   always_comb begin
      unlocked_in   = unlocked_ff;
      claim_in      = claim_ff;
      index_in      = index_ff;
      key_last_in   = key_last_ff;
      key_prev_in   = key_prev_ff;
      active_key_in = active_key_ff;
      key_sel_in    = key_sel_ff;
      mapping_in    = mapping_ff;
      rd_sel_in     = rd_sel_ff;
      mem_we        = 1'b0;
      for (int i = 0; i < DEV_COUNT; i++) begin
         dev_in[i] = dev_ff[i];
      end

      if (init) begin
         unlocked_in   = 1'b0;
         claim_in      = 1'b1;
         index_in      = '0;
         key_last_in   = '0;
         key_prev_in   = '0;
         active_key_in = cfg.initial_key;
         key_sel_in    = (cfg.initial_key == KEY_250_LOW || cfg.initial_key == KEY_3F0_LOW) ?
                         KEY_SEL_LOW : KEY_SEL_HIGH;
         mapping_in    = cfg.base_select ? MAP_3F0_DEF : MAP_250_DEF;
         for (int i = 0; i < DEV_COUNT; i++) begin
            dev_in[i] = dev_default(3'(i));
         end
      end else if (accept) begin
         rd_sel_in.use_mem = 1'b0;
         rd_sel_in.value   = opcode ? 8'h00 : BYTE_ALL_ONES;

         if (!alt_map) begin
            if (opcode) begin
               if (io_address == PORT_KEY_250) begin
                  unlocked_in = (write_data == active_key_ff);
               end else if (io_address == PORT_INDEX_250 && unlocked_ff) begin
                  index_in = write_data;
               end
            end else if (io_address == PORT_INDEX_250 && unlocked_ff) begin
               rd_sel_in.value = index_ff;
            end
         end else begin
            if (opcode) begin
               if (io_address == PORT_INDEX_3F0) begin
                  if (write_data == LOCK_BYTE) begin
                     claim_in    = 1'b1;
                     unlocked_in = 1'b0;
                  end else if (!unlocked_ff) begin
                     key_prev_in = key_last_ff;
                     key_last_in = write_data;
                     unlocked_in = key_hit;
                     if (key_hit) begin
                        claim_in = 1'b0;
                     end
                  end else begin
                     index_in = write_data;
                  end
               end
            end else if (io_address == PORT_INDEX_3F0 && unlocked_ff) begin
               rd_sel_in.value = index_ff;
            end
         end

         if (data_wr && in_range) begin
            if (index_ff == IDX_KEY_SEL) begin
               active_key_in = pick_key(alt_map, write_data);
               key_sel_in    = write_data;
            end else if (index_ff == IDX_MAPPING) begin
               if (write_data != MAP_IGNORED) begin
                  active_key_in = pick_key(write_data[0], key_sel_ff);
                  mapping_in    = write_data;
                  if (mapping_ff[2] && !write_data[2]) begin
                     for (int i = 0; i < DEV_COUNT; i++) begin
                        dev_in[i] = 8'h00;
                     end
                  end
               end
            end else if (is_dev) begin
               dev_in[dev_slot] = write_data;
            end else begin
               mem_we = 1'b1;
            end
         end

         if (data_rd) begin
            if (index_ff == IDX_CHIP_ID) begin
               rd_sel_in.value = chip_id(cfg.chip_variant);
            end else if (!in_range) begin
               rd_sel_in.value = BYTE_ALL_ONES;
            end else if (index_ff == IDX_KEY_SEL) begin
               rd_sel_in.value = key_sel_ff;
            end else if (index_ff == IDX_MAPPING) begin
               rd_sel_in.value = mapping_ff;
            end else if (is_dev) begin
               rd_sel_in.value = dev_ff[dev_slot];
            end else if (valid_ff[mem_addr]) begin
               rd_sel_in.use_mem = 1'b1;
            end else begin
               rd_sel_in.value = mem_default(index_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unlocked_ff <= 1'b0;
         claim_ff    <= 1'b1;
         index_ff    <= '0;
         key_last_ff <= '0;
         key_prev_ff <= '0;
         valid_ff    <= '0;
      end else begin
         unlocked_ff <= unlocked_in;
         claim_ff    <= claim_in;
         index_ff    <= index_in;
         key_last_ff <= key_last_in;
         key_prev_ff <= key_prev_in;
         if (init) begin
            valid_ff <= '0;
         end else if (mem_we) begin
            valid_ff[mem_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      active_key_ff <= active_key_in;
      key_sel_ff    <= key_sel_in;
      mapping_ff    <= mapping_in;
      rd_sel_ff     <= rd_sel_in;
      for (int i = 0; i < DEV_COUNT; i++) begin
         dev_ff[i] <= dev_in[i];
      end
   end

   sioreg_ram #(
      .DEPTH (REG_COUNT),
      .WIDTH (8)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_addr),
      .wr_data (write_data),
      .rd_en   (accept),
      .rd_addr (mem_addr),
      .rd_data (mem_rdata)
   );

   assign rd_data = rd_sel_ff.use_mem ? mem_rdata : rd_sel_ff.value;

   assign status.fdc_on             = dev_ff[DEV_FDC][7:6] != 2'b00;
   assign status.fdc_shared_port_on = claim_ff;
   assign status.lpt_on             = dev_ff[DEV_LPT][7:6] != 2'b00;
   assign status.lpt_base           = {dev_ff[DEV_LPT], 2'b00};
   assign status.uart1_on           = dev_ff[DEV_UART1][7:6] != 2'b00;
   assign status.uart1_base         = {dev_ff[DEV_UART1][7:1], 3'b000};
   assign status.uart1_irq          = dev_ff[DEV_IRQ][7:4];
   assign status.uart2_on           = dev_ff[DEV_UART2][7:6] != 2'b00;
   assign status.uart2_base         = {dev_ff[DEV_UART2][7:1], 3'b000};
   assign status.uart2_irq          = dev_ff[DEV_IRQ][3:0];

endmodule

FILE: rtl/core/superio_config_unlock_regfile.sv
// Top level of the Super I/O configuration unlock and index/data register file.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall opcode, io_address, write_data
//   rsp      out        rsp_valid/rsp_stall read_data and decoded device settings
//   csr      in/out     APB psel/penable    chip_variant, base_select, initial_key
//
// Each item is decoded and updates state in ST_IDLE, then waits in ST_FETCH for the memory read.
// The next item is taken while the previous result waits in the output register.
// After reset, and after a write to any of the three configuration registers, req_stall
// is high for one cycle while the state is reloaded from the configuration registers.
// A stalled result holds the fetch stage, which then holds the input.
module superio_config_unlock_regfile (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_opcode,
   input  logic [9:0]                  req_io_address,
   input  logic [7:0]                  req_write_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_read_data,
   output logic                        rsp_fdc_on,
   output logic                        rsp_fdc_shared_port_on,
   output logic                        rsp_lpt_on,
   output logic [9:0]                  rsp_lpt_base,
   output logic                        rsp_uart1_on,
   output logic [9:0]                  rsp_uart1_base,
   output logic [3:0]                  rsp_uart1_irq,
   output logic                        rsp_uart2_on,
   output logic [9:0]                  rsp_uart2_base,
   output logic [3:0]                  rsp_uart2_irq,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sioreg_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import sioreg_pkg::*;

   state_type      state_ff, state_in;
   cfg_type        cfg_ff;
   logic           init_ff;
   logic           csr_wr;
   logic [1:0]     csr_idx;
   logic           accept;
   logic           load_out;
   logic           rsp_valid_ff;
   logic [7:0]     read_data_ff;
   dev_status_type status_ff;
   logic [7:0]     core_rd_data;
   dev_status_type core_status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      case (csr_idx)
         CSR_CHIP_VARIANT: csr_prdata = {31'd0, cfg_ff.chip_variant};
         CSR_BASE_SELECT:  csr_prdata = {31'd0, cfg_ff.base_select};
         CSR_INITIAL_KEY:  csr_prdata = {24'd0, cfg_ff.initial_key};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chip_variant <= 1'b1;
         cfg_ff.base_select  <= 1'b0;
         cfg_ff.initial_key  <= 8'h89;
         init_ff             <= 1'b1;
      end else begin
         init_ff <= 1'b0;
         if (csr_wr) begin
            case (csr_idx)
               CSR_CHIP_VARIANT: begin
                  cfg_ff.chip_variant <= csr_pwdata[0];
                  init_ff             <= 1'b1;
               end
               CSR_BASE_SELECT: begin
                  cfg_ff.base_select <= csr_pwdata[0];
                  init_ff            <= 1'b1;
               end
               CSR_INITIAL_KEY: begin
                  cfg_ff.initial_key <= csr_pwdata[7:0];
                  init_ff            <= 1'b1;
               end
               default: begin
                  init_ff <= 1'b0;
               end
            endcase
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !init_ff) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE:  req_stall = init_ff;
         ST_FETCH: load_out  = !rsp_valid_ff || !rsp_stall;
         default:  req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         read_data_ff <= core_rd_data;
         status_ff    <= core_status;
      end
   end

   sioreg_core u_core (
      .clock      (clock),
      .reset      (reset),
      .init       (init_ff),
      .cfg        (cfg_ff),
      .accept     (accept),
      .opcode     (req_opcode),
      .io_address (req_io_address),
      .write_data (req_write_data),
      .rd_data    (core_rd_data),
      .status     (core_status)
   );

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_read_data          = read_data_ff;
   assign rsp_fdc_on             = status_ff.fdc_on;
   assign rsp_fdc_shared_port_on = status_ff.fdc_shared_port_on;
   assign rsp_lpt_on             = status_ff.lpt_on;
   assign rsp_lpt_base           = status_ff.lpt_base;
   assign rsp_uart1_on           = status_ff.uart1_on;
   assign rsp_uart1_base         = status_ff.uart1_base;
   assign rsp_uart1_irq          = status_ff.uart1_irq;
   assign rsp_uart2_on           = status_ff.uart2_on;
   assign rsp_uart2_base         = status_ff.uart2_base;
   assign rsp_uart2_irq          = status_ff.uart2_irq;

endmodule

FILE: tb/sv/sio_regfile_checker.sv
// Checker for the Super I/O register file: predicts every bus access result and compares it.
`timescale 1ns / 1ps
module sio_regfile_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic                             req_opcode,
   input  logic [9:0]                       req_io_address,
   input  logic [7:0]                       req_write_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [7:0]                       rsp_read_data,
   input  logic                             rsp_fdc_on,
   input  logic                             rsp_fdc_shared_port_on,
   input  logic                             rsp_lpt_on,
   input  logic [9:0]                       rsp_lpt_base,
   input  logic                             rsp_uart1_on,
   input  logic [9:0]                       rsp_uart1_base,
   input  logic [3:0]                       rsp_uart1_irq,
   input  logic                             rsp_uart2_on,
   input  logic [9:0]                       rsp_uart2_base,
   input  logic [3:0]                       rsp_uart2_irq,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic                             csr_pready,
   input  logic [sioreg_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output int                               mismatches,
   output int                               outstanding
);
   import sioreg_pkg::*;

   localparam logic [7:0] KEY_250_HI = 8'h89;
   localparam logic [7:0] KEY_250_LO = 8'h88;
   localparam logic [7:0] KEY_3F0_HI = 8'h87;
   localparam logic [7:0] KEY_3F0_LO = 8'h86;
   localparam logic [7:0] IDX_UART1  = 8'h24;
   localparam logic [7:0] IDX_UART2  = 8'h25;
   localparam logic [7:0] IDX_IRQ    = 8'h28;
   localparam logic [7:0] DEV_ON_LEVEL = 8'h40;
   localparam logic [7:0] CHIP_ID_A  = 8'h0a;
   localparam logic [7:0] CHIP_ID_C  = 8'h0c;

   typedef struct packed {
      logic [7:0]     read_data;
      dev_status_type dev;
   } access_result_t;

   logic       strap_variant;
   logic       strap_base;
   logic [7:0] strap_key;

   logic [7:0] cfg_regs [0:REG_COUNT-1];
   logic [7:0] cfg_index;
   logic       unlocked;
   logic [7:0] key_last;
   logic [7:0] key_prev;
   logic [7:0] active_key;
   logic       port_claim;

   access_result_t expected_accesses [$];

   function automatic logic [7:0] key_for(input logic alt, input logic sel_hi);
      if (alt) return sel_hi ? KEY_3F0_HI : KEY_3F0_LO;
      return sel_hi ? KEY_250_HI : KEY_250_LO;
   endfunction

   function automatic void reload_state();
      for (int i = 0; i < REG_COUNT; i++) cfg_regs[i] = 8'h00;
      cfg_regs[8'h03] = 8'h30;
      cfg_regs[IDX_CHIP_ID] = 8'h0c;
      cfg_regs[8'h0b] = 8'h0c;
      cfg_regs[IDX_KEY_SEL] = (strap_key == KEY_250_LO || strap_key == KEY_3F0_LO) ?
                              KEY_SEL_LOW : KEY_SEL_HIGH;
      cfg_regs[8'h0d] = 8'ha3;
      cfg_regs[IDX_MAPPING] = strap_base ? MAP_3F0_DEF : MAP_250_DEF;
      cfg_regs[IDX_FDC] = 8'hfc;
      cfg_regs[IDX_LPT] = 8'hde;
      cfg_regs[IDX_UART1] = 8'hfe;
      cfg_regs[IDX_UART2] = 8'hbe;
      cfg_regs[8'h26] = 8'h23;
      cfg_regs[8'h27] = 8'h05;
      cfg_regs[IDX_IRQ] = 8'h43;
      cfg_regs[IDX_LAST_DEV] = 8'h60;
      cfg_index = 8'h00;
      unlocked = 1'b0;
      key_last = 8'h00;
      key_prev = 8'h00;
      active_key = strap_key;
      port_claim = 1'b1;
   endfunction

   function automatic void store_register(input logic [7:0] idx, input logic [7:0] val);
      if (int'(idx) >= REG_COUNT) return;
      if (idx == IDX_KEY_SEL) begin
         active_key = key_for(cfg_regs[IDX_MAPPING][0], val[5]);
      end else if (idx == IDX_MAPPING) begin
         if (val == MAP_IGNORED) return;
         active_key = key_for(val[0], cfg_regs[IDX_KEY_SEL][5]);
         if (cfg_regs[IDX_MAPPING][2] && !val[2]) begin
            cfg_regs[IDX_FDC] = 8'h00;
            for (int i = IDX_LPT; i <= IDX_LAST_DEV; i++) cfg_regs[i] = 8'h00;
         end
      end
      cfg_regs[idx] = val;
   endfunction

   function automatic logic [7:0] load_register(input logic [7:0] idx);
      if (idx == IDX_CHIP_ID) return strap_variant ? CHIP_ID_C : CHIP_ID_A;
      if (int'(idx) >= REG_COUNT) return BYTE_ALL_ONES;
      return cfg_regs[idx];
   endfunction

   function automatic access_result_t predict_access(input logic is_write,
                                                     input logic [9:0] addr,
                                                     input logic [7:0] data);
      access_result_t res;
      logic [7:0] rd;
      rd = BYTE_ALL_ONES;
      if (!cfg_regs[IDX_MAPPING][0]) begin
         if (is_write) begin
            if (addr == PORT_KEY_250) unlocked = (data == active_key);
            else if (addr == PORT_INDEX_250 && unlocked) cfg_index = data;
            else if (addr == PORT_DATA_250 && unlocked) store_register(cfg_index, data);
         end else begin
            if (addr == PORT_INDEX_250 && unlocked) rd = cfg_index;
            else if (addr == PORT_DATA_250 && unlocked) rd = load_register(cfg_index);
         end
      end else begin
         if (is_write) begin
            if (addr == PORT_INDEX_3F0) begin
               if (data == LOCK_BYTE) begin
                  port_claim = 1'b1;
                  unlocked = 1'b0;
               end else if (!unlocked) begin
                  key_prev = key_last;
                  key_last = data;
                  unlocked = (key_last == active_key && key_prev == active_key);
                  if (unlocked) port_claim = 1'b0;
               end else begin
                  cfg_index = data;
               end
            end else if (addr == PORT_DATA_3F0 && unlocked) begin
               store_register(cfg_index, data);
            end
         end else begin
            if (addr == PORT_INDEX_3F0 && unlocked) rd = cfg_index;
            else if (addr == PORT_DATA_3F0 && unlocked) rd = load_register(cfg_index);
         end
      end
      res.read_data = is_write ? 8'h00 : rd;
      res.dev.fdc_on = cfg_regs[IDX_FDC] >= DEV_ON_LEVEL;
      res.dev.fdc_shared_port_on = port_claim;
      res.dev.lpt_on = cfg_regs[IDX_LPT] >= DEV_ON_LEVEL;
      res.dev.lpt_base = {cfg_regs[IDX_LPT], 2'b00};
      res.dev.uart1_on = cfg_regs[IDX_UART1] >= DEV_ON_LEVEL;
      res.dev.uart1_base = {cfg_regs[IDX_UART1][7:1], 3'b000};
      res.dev.uart1_irq = cfg_regs[IDX_IRQ][7:4];
      res.dev.uart2_on = cfg_regs[IDX_UART2] >= DEV_ON_LEVEL;
      res.dev.uart2_base = {cfg_regs[IDX_UART2][7:1], 3'b000};
      res.dev.uart2_irq = cfg_regs[IDX_IRQ][3:0];
      return res;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      access_result_t want;
      logic           strap_hit;
      if (reset) begin
         strap_variant = 1'b1;
         strap_base = 1'b0;
         strap_key = KEY_250_HI;
         reload_state();
         expected_accesses.delete();
         mismatches = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            strap_hit = 1'b1;
            case (csr_paddr[CSR_AW-1:2])
               CSR_CHIP_VARIANT: strap_variant = csr_pwdata[0];
               CSR_BASE_SELECT:  strap_base = csr_pwdata[0];
               CSR_INITIAL_KEY:  strap_key = csr_pwdata[7:0];
               default: strap_hit = 1'b0;
            endcase
            if (strap_hit) reload_state();
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_accesses.size() == 0) begin
               $display("%0t: result with no access pending, actual read_data 0x%0h",
                        $time, rsp_read_data);
               mismatches++;
            end else begin
               want = expected_accesses.pop_front();
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("fdc_on", want.dev.fdc_on, rsp_fdc_on);
               check_field("fdc_shared_port_on", want.dev.fdc_shared_port_on,
                           rsp_fdc_shared_port_on);
               check_field("lpt_on", want.dev.lpt_on, rsp_lpt_on);
               check_field("lpt_base", want.dev.lpt_base, rsp_lpt_base);
               check_field("uart1_on", want.dev.uart1_on, rsp_uart1_on);
               check_field("uart1_base", want.dev.uart1_base, rsp_uart1_base);
               check_field("uart1_irq", want.dev.uart1_irq, rsp_uart1_irq);
               check_field("uart2_on", want.dev.uart2_on, rsp_uart2_on);
               check_field("uart2_base", want.dev.uart2_base, rsp_uart2_base);
               check_field("uart2_irq", want.dev.uart2_irq, rsp_uart2_irq);
            end
         end
         if (req_valid && !req_stall)
            expected_accesses.push_back(predict_access(req_opcode, req_io_address,
                                                       req_write_data));
      end
      outstanding = expected_accesses.size();
   end

endmodule

FILE: tb/sv/tb.sv
// Testbench top: drives bus accesses and strap settings into the Super I/O register file.
`timescale 1ns / 1ps
module tb;
   import sioreg_pkg::*;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;
   localparam logic [7:0] KEY_250_HI = 8'h89;
   localparam logic [7:0] KEY_250_LO = 8'h88;
   localparam logic [7:0] KEY_3F0_HI = 8'h87;
   localparam logic [7:0] KEY_3F0_LO = 8'h86;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 50;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_opcode = 1'b0;
   logic [9:0]          req_io_address = '0;
   logic [7:0]          req_write_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [7:0]          rsp_read_data;
   logic                rsp_fdc_on;
   logic                rsp_fdc_shared_port_on;
   logic                rsp_lpt_on;
   logic [9:0]          rsp_lpt_base;
   logic                rsp_uart1_on;
   logic [9:0]          rsp_uart1_base;
   logic [3:0]          rsp_uart1_irq;
   logic                rsp_uart2_on;
   logic [9:0]          rsp_uart2_base;
   logic [3:0]          rsp_uart2_irq;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;
   int                  mismatches;
   int                  outstanding;

   int         tx_idle_pct = 0;
   int         rx_stall_pct = 0;
   int         hold_requests = 0;
   int         hold_served = 0;
   int         hold_left = 0;
   int         items_sent = 0;
   int         writes_sent = 0;
   int         phase_items = 0;
   logic       believed_alt;
   logic       believed_sel_hi;
   logic [7:0] believed_key;

   superio_config_unlock_regfile dut (.*);
   sio_regfile_checker access_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // The receiver either stalls at random or, on request, holds off for a long stretch.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_stall_pct);
         end
      end
   end

   function automatic logic [7:0] key_for(input logic alt, input logic sel_hi);
      if (alt) return sel_hi ? KEY_3F0_HI : KEY_3F0_LO;
      return sel_hi ? KEY_250_HI : KEY_250_LO;
   endfunction

   task automatic send(input logic op, input logic [9:0] addr, input logic [7:0] data);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_io_address <= addr;
      req_write_data <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      phase_items++;
      if (op == OP_WRITE) writes_sent++;
   endtask

   task automatic drain_items();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] reg_idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic register_access();
      logic [7:0] idx;
      logic [7:0] val;
      logic [9:0] index_port;
      logic [9:0] data_port;
      index_port = believed_alt ? PORT_INDEX_3F0 : PORT_INDEX_250;
      data_port = believed_alt ? PORT_DATA_3F0 : PORT_DATA_250;
      case ($urandom_range(9))
         0: idx = IDX_CHIP_ID;
         1: idx = IDX_KEY_SEL;
         2: idx = IDX_MAPPING;
         3, 4, 5: idx = 8'($urandom_range(IDX_FDC, IDX_LAST_DEV));
         6: idx = 8'hff;
         7: idx = 8'h00;
         default: idx = 8'($urandom_range(255));
      endcase
      send(OP_WRITE, index_port, idx);
      if ($urandom_range(1) == 0) begin
         send(OP_READ, data_port, 8'($urandom_range(255)));
      end else begin
         if (idx == IDX_MAPPING) begin
            case ($urandom_range(5))
               0: val = MAP_IGNORED;
               1: val = 8'h00;
               2: val = 8'h01;
               3: val = MAP_250_DEF;
               4: val = MAP_3F0_DEF;
               default: val = 8'($urandom_range(255));
            endcase
         end else begin
            val = 8'($urandom_range(255));
         end
         send(OP_WRITE, data_port, val);
         if (!(believed_alt && idx == LOCK_BYTE)) begin
            if (idx == IDX_KEY_SEL) begin
               believed_sel_hi = val[5];
               believed_key = key_for(believed_alt, val[5]);
            end else if (idx == IDX_MAPPING && val != MAP_IGNORED) begin
               believed_alt = val[0];
               believed_key = key_for(val[0], believed_sel_hi);
            end
         end
      end
      if ($urandom_range(3) == 0) send(OP_READ, index_port, 8'($urandom_range(255)));
   endtask

   // Mostly an unlock, a few index/data accesses and sometimes a lock; the rest is noise.
   task automatic run_session();
      logic [9:0] addr;
      if ($urandom_range(99) < 25) begin
         case ($urandom_range(7))
            0: addr = PORT_KEY_250;
            1: addr = PORT_INDEX_250;
            2: addr = PORT_DATA_250;
            3: addr = PORT_INDEX_3F0;
            4: addr = PORT_DATA_3F0;
            default: addr = 10'($urandom_range(1023));
         endcase
         send(logic'($urandom_range(1)), addr, 8'($urandom_range(255)));
         return;
      end
      if (believed_alt) begin
         send(OP_WRITE, PORT_INDEX_3F0, believed_key);
         send(OP_WRITE, PORT_INDEX_3F0, believed_key);
      end else begin
         send(OP_WRITE, PORT_KEY_250, believed_key);
      end
      repeat ($urandom_range(1, 5)) register_access();
      if ($urandom_range(3) == 0) begin
         if (believed_alt) send(OP_WRITE, PORT_INDEX_3F0, LOCK_BYTE);
         else send(OP_WRITE, PORT_KEY_250, 8'($urandom_range(255)));
      end
   endtask

   initial begin
      logic       strap_variant;
      logic       strap_base;
      logic [7:0] strap_key;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Power-on straps: 250h mapping, key 89h.
      send(OP_READ,  PORT_DATA_250,  8'h00);
      send(OP_WRITE, PORT_INDEX_250, IDX_KEY_SEL);
      send(OP_WRITE, PORT_KEY_250,   KEY_250_LO);
      send(OP_WRITE, PORT_KEY_250,   KEY_250_HI);
      send(OP_READ,  PORT_KEY_250,   8'hff);
      send(OP_WRITE, PORT_INDEX_250, IDX_CHIP_ID);
      send(OP_READ,  PORT_DATA_250,  8'h00);
      send(OP_READ,  PORT_INDEX_250, 8'h00);
      send(OP_WRITE, PORT_DATA_250,  8'h55);
      send(OP_READ,  PORT_DATA_250,  8'h00);
      send(OP_WRITE, PORT_INDEX_250, IDX_KEY_SEL);
      send(OP_WRITE, PORT_DATA_250,  8'h00);
      send(OP_WRITE, PORT_INDEX_250, IDX_MAPPING);
      send(OP_WRITE, PORT_DATA_250,  MAP_IGNORED);
      send(OP_READ,  PORT_DATA_250,  8'h00);
      send(OP_WRITE, PORT_DATA_250,  8'h00);
      send(OP_WRITE, PORT_DATA_250,  MAP_3F0_DEF);
      send(OP_READ,  PORT_DATA_3F0,  8'h00);
      send(OP_WRITE, PORT_INDEX_3F0, LOCK_BYTE);
      send(OP_READ,  PORT_INDEX_3F0, 8'h00);
      send(OP_WRITE, PORT_INDEX_3F0, KEY_3F0_LO);
      send(OP_WRITE, PORT_INDEX_3F0, KEY_3F0_LO);
      send(OP_WRITE, PORT_INDEX_3F0, IDX_LPT);
      send(OP_WRITE, PORT_DATA_3F0,  8'hff);
      send(OP_READ,  PORT_DATA_3F0,  8'h00);
      send(OP_READ,  10'h000,        8'h00);
      send(OP_WRITE, 10'h3ff,        8'hff);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_items();
         strap_variant = (phase % 2 == 0);
         strap_base = 1'((phase / 2) % 2);
         strap_key = KEY_3F0_LO + 8'((phase + phase / 4) % 4);
         write_csr(CSR_CHIP_VARIANT, {31'd0, strap_variant});
         write_csr(CSR_BASE_SELECT, {31'd0, strap_base});
         write_csr(CSR_INITIAL_KEY, {24'd0, strap_key});
         believed_alt = strap_base;
         believed_sel_hi = !(strap_key == KEY_250_LO || strap_key == KEY_3F0_LO);
         believed_key = strap_key;
         case (phase % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 49; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
            default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
         endcase
         if (phase == 4) hold_requests++;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) run_session();
      end

      drain_items();
      repeat (8) @(posedge clock);
      $display("Ran %0d bus accesses (%0d writes) through %0d strap settings,", items_sent,
               writes_sent, PHASE_COUNT + 1);
      $display("with idle and stall mixes and one long result hold-off.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: superio_config_unlock_regfile.f
rtl/core/sioreg_pkg.sv
rtl/core/sioreg_ram.sv
rtl/core/sioreg_core.sv
rtl/core/superio_config_unlock_regfile.sv
tb/sv/sio_regfile_checker.sv
tb/sv/tb.sv
